// ----- rtl/core/psad_pkg.sv -----
// Shared types, constants and the arctangent table of the bearing and distance block.
`default_nettype none
package psad_pkg;

	localparam int COORD_BITS   = 24;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int DIST_BITS    = 24;
	localparam int CORDIC_STEPS = 16;
	localparam int PRESCALE     = 59 - COORD_BITS;
	localparam int CW           = 62;
	localparam int ZW           = 32;
	localparam int BEAR_BITS    = 9;
	localparam int SQ_BITS      = 2 * DIST_BITS;
	localparam int SUM_BITS     = SQ_BITS + 1;
	localparam int RAD_BITS     = 64;
	localparam int ROOT_BITS    = 32;
	localparam int QUO_BITS     = 8;
	localparam int DIST_LAT     = 4 + ROOT_BITS + QUO_BITS;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int PIPE_LAT     = DIST_LAT;
	localparam int BEAR_PAD     = PIPE_LAT - CORDIC_LAT;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = 2;

	localparam logic REG_MAX_DISTANCE   = 1'b0;
	localparam logic REG_SPATIAL_ENABLE = 1'b1;

	localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = 24'd25600;
	localparam logic signed [ZW-1:0] DEG180_Q16     = 32'sd11796480;
	localparam logic signed [BEAR_BITS-1:0] DEG180  = 9'sd180;

	typedef struct packed {
		logic                        off;
		logic                        zero;
		logic                        behind;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
	} item_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = 32'sd2949120;
			1:  v = 32'sd1740967;
			2:  v = 32'sd919879;
			3:  v = 32'sd466945;
			4:  v = 32'sd234379;
			5:  v = 32'sd117304;
			6:  v = 32'sd58666;
			7:  v = 32'sd29335;
			8:  v = 32'sd14668;
			9:  v = 32'sd7334;
			10: v = 32'sd3667;
			11: v = 32'sd1833;
			12: v = 32'sd917;
			13: v = 32'sd458;
			14: v = 32'sd229;
			15: v = 32'sd115;
			16: v = 32'sd57;
			17: v = 32'sd29;
			18: v = 32'sd14;
			19: v = 32'sd7;
			20: v = 32'sd4;
			21: v = 32'sd2;
			22: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/psad_front.sv -----
// Front end: accepts requests, forms the direction vector, classifies it and queues it.
`default_nettype none
module psad_front (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  listener_x,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  listener_y,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  source_x,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  source_y,
	input  wire logic                                    spatial_enable,
	input  wire logic                                    take,
	output logic                                         avail,
	output psad_pkg::item_t                              head
);

	psad_pkg::item_t                   mem_q [psad_pkg::QUEUE_DEPTH];
	logic [psad_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [psad_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [psad_pkg::QPTR_BITS:0]      count_q;
	psad_pkg::item_t                   item;
	logic                              wr;
	logic                              rd;

	always_comb begin
		item.dx     = {listener_x[psad_pkg::COORD_BITS-1], listener_x}
			- {source_x[psad_pkg::COORD_BITS-1], source_x};
		item.dy     = {listener_y[psad_pkg::COORD_BITS-1], listener_y}
			- {source_y[psad_pkg::COORD_BITS-1], source_y};
		item.off    = !spatial_enable;
		item.zero   = (item.dx == '0) && (item.dy == '0);
		item.behind = (item.dx == '0) && item.dy[psad_pkg::DIFF_BITS-1];
	end

	assign full  = (count_q == (psad_pkg::QPTR_BITS+1)'(psad_pkg::QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];
	assign wr    = push && !full;
	assign rd    = take && avail;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/psad_cordic.sv -----
// Bearing pipeline: CORDIC vectoring, one rotation per stage, then delay to the common depth.
`default_nettype none
module psad_cordic (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire psad_pkg::item_t                         item,
	output logic signed [psad_pkg::BEAR_BITS-1:0]        bearing
);

	localparam int N = psad_pkg::CORDIC_STEPS;

	logic signed [psad_pkg::CW-1:0]        x_s   [0:N];
	logic signed [psad_pkg::CW-1:0]        y_s   [0:N];
	logic signed [psad_pkg::ZW-1:0]        z_s   [0:N];
	logic                                  fix_s [0:N];
	logic signed [psad_pkg::BEAR_BITS-1:0] fv_s  [0:N];
	logic signed [psad_pkg::BEAR_BITS-1:0] bd_s  [0:psad_pkg::BEAR_PAD];

	logic signed [psad_pkg::CW-1:0] x0, y0;
	logic signed [psad_pkg::ZW-1:0] zabs, zq;
	logic signed [psad_pkg::ZW-1:0] zf;

	always_comb begin
		x0 = psad_pkg::CW'(item.dy) <<< psad_pkg::PRESCALE;
		y0 = (-psad_pkg::CW'(item.dx)) <<< psad_pkg::PRESCALE;
	end

	// Prescale; fold the left half plane over by starting at +/-180
	always_ff @(posedge clk) begin
		if (en) begin
			if (x0 < 0) begin
				x_s[0] <= -x0;
				y_s[0] <= -y0;
				z_s[0] <= (y0 > 0) ? psad_pkg::DEG180_Q16 : -psad_pkg::DEG180_Q16;
			end else begin
				x_s[0] <= x0;
				y_s[0] <= y0;
				z_s[0] <= '0;
			end
			fix_s[0] <= item.zero || item.behind;
			fv_s[0]  <= item.behind ? -psad_pkg::DEG180 : '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + psad_pkg::atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - psad_pkg::atan_q16(i);
				end
				fix_s[i+1] <= fix_s[i];
				fv_s[i+1]  <= fv_s[i];
			end
		end
	end

	// Whole degrees, truncated toward zero, clamped
	always_comb begin
		zf   = z_s[N];
		zabs = zf[psad_pkg::ZW-1] ? -zf : zf;
		zq   = zabs >>> 16;
		if (zq > psad_pkg::ZW'(psad_pkg::DEG180)) begin
			zq = psad_pkg::ZW'(psad_pkg::DEG180);
		end
		if (zf[psad_pkg::ZW-1]) begin
			zq = -zq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bd_s[0] <= fix_s[N] ? fv_s[N] : zq[psad_pkg::BEAR_BITS-1:0];
		end
	end

	for (genvar j = 0; j < psad_pkg::BEAR_PAD; j++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				bd_s[j+1] <= bd_s[j];
			end
		end
	end

	assign bearing = bd_s[psad_pkg::BEAR_PAD];

endmodule
`default_nettype wire

// ----- rtl/core/psad_dist.sv -----
// Distance pipeline: squares, bit-per-stage square root, bit-per-stage divide by the maximum.
`default_nettype none
module psad_dist (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire psad_pkg::item_t                         item,
	input  wire logic [psad_pkg::DIST_BITS-1:0]          max_distance,
	output logic [psad_pkg::QUO_BITS-1:0]                distance
);

	localparam int RB = psad_pkg::ROOT_BITS;
	localparam int QB = psad_pkg::QUO_BITS;

	logic [psad_pkg::DIST_BITS-1:0] m;
	logic [psad_pkg::DIFF_BITS-1:0] ax, ay;

	logic [psad_pkg::DIFF_BITS-1:0] ax_s1, ay_s1;
	logic                           sat_s1, sat_s2, sat_s3, sat_s4;
	logic [psad_pkg::SQ_BITS-1:0]   sqx_s2, sqy_s2, mm_s2;
	logic [psad_pkg::SUM_BITS-1:0]  sum_s3;
	logic [psad_pkg::RAD_BITS-1:0]  rad_s4;

	logic [psad_pkg::RAD_BITS-1:0]  rem_s  [0:RB];
	logic [RB-1:0]                  root_s [0:RB];
	logic                           rsat_s [0:RB];
	logic [RB-1:0]                  dr_s   [0:QB];
	logic [QB-1:0]                  q_s    [0:QB];
	logic                           dsat_s [0:QB];

	assign m  = (max_distance == '0) ? psad_pkg::DIST_BITS'(1) : max_distance;
	assign ax = item.dx[psad_pkg::DIFF_BITS-1] ? psad_pkg::DIFF_BITS'(-item.dx)
		: psad_pkg::DIFF_BITS'(item.dx);
	assign ay = item.dy[psad_pkg::DIFF_BITS-1] ? psad_pkg::DIFF_BITS'(-item.dy)
		: psad_pkg::DIFF_BITS'(item.dy);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= ax;
			ay_s1  <= ay;
			sat_s1 <= (ax >= {1'b0, m}) || (ay >= {1'b0, m});
			sqx_s2 <= ax_s1[psad_pkg::DIST_BITS-1:0] * ax_s1[psad_pkg::DIST_BITS-1:0];
			sqy_s2 <= ay_s1[psad_pkg::DIST_BITS-1:0] * ay_s1[psad_pkg::DIST_BITS-1:0];
			mm_s2  <= m * m;
			sat_s2 <= sat_s1;
			sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			sat_s3 <= sat_s2 || (({1'b0, sqx_s2} + {1'b0, sqy_s2}) >= {1'b0, mm_s2});
			// 65025 = 65536 - 512 + 1
			rad_s4 <= (psad_pkg::RAD_BITS'(sum_s3) << 16) - (psad_pkg::RAD_BITS'(sum_s3) << 9)
				+ psad_pkg::RAD_BITS'(sum_s3);
			sat_s4 <= sat_s3;
		end
	end

	assign rem_s[0]  = rad_s4;
	assign root_s[0] = '0;
	assign rsat_s[0] = sat_s4;

	// Square root, one result bit per stage, high bit first
	for (genvar j = 0; j < RB; j++) begin : g_root
		localparam int K = RB - 1 - j;
		logic [psad_pkg::RAD_BITS:0] delta;
		assign delta = ((psad_pkg::RAD_BITS+1)'(root_s[j]) << (K + 1))
			+ ((psad_pkg::RAD_BITS+1)'(1) << (2 * K));
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[j]} >= delta) begin
					rem_s[j+1]  <= rem_s[j] - delta[psad_pkg::RAD_BITS-1:0];
					root_s[j+1] <= root_s[j] | (RB'(1) << K);
				end else begin
					rem_s[j+1]  <= rem_s[j];
					root_s[j+1] <= root_s[j];
				end
				rsat_s[j+1] <= rsat_s[j];
			end
		end
	end

	assign dr_s[0]   = root_s[RB];
	assign q_s[0]    = '0;
	assign dsat_s[0] = rsat_s[RB];

	// Restoring divide by the maximum; the quotient stays below 256
	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int K = QB - 1 - j;
		logic [RB-1:0] dv;
		assign dv = RB'(m) << K;
		always_ff @(posedge clk) begin
			if (en) begin
				if (dr_s[j] >= dv) begin
					dr_s[j+1] <= dr_s[j] - dv;
					q_s[j+1]  <= q_s[j] | (QB'(1) << K);
				end else begin
					dr_s[j+1] <= dr_s[j];
					q_s[j+1]  <= q_s[j];
				end
				dsat_s[j+1] <= dsat_s[j];
			end
		end
	end

	assign distance = dsat_s[QB] ? '1 : q_s[QB];

endmodule
`default_nettype wire

// ----- rtl/core/positional_sound_angle_distance.sv -----
// Top level: bearing and distance attenuation of a sound source seen from a listener.
//
//  channel   | handshake      | payload
//  ----------+----------------+----------------------------------------------------
//  request   | push / full    | listener_x, listener_y, source_x, source_y (s24 Q16.8)
//  result    | pop / empty    | bearing_degrees (s9), distance_byte (u8)
//  config    | cfg_wr_en      | cfg_index (0 max_distance, 1 spatial_enable), cfg_wdata
//
// One request per cycle is taken and one result per cycle is given while the receiver
// keeps popping; a request waits in the front queue and then passes through the
// 44-stage back pipeline, whose depth is set by the 4 squaring stages,
// the 32-stage square root and the 8-stage divider of the distance path.
// A stalled result freezes the whole back pipeline; the 4-entry queue keeps taking
// requests until it fills. Reset empties the queue and the pipeline and loads
// max_distance = 25600, spatial_enable = 0. No clearing pass is needed.
`default_nettype none
module positional_sound_angle_distance (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	output logic                                         full,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  listener_x,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  listener_y,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  source_x,
	input  wire logic signed [psad_pkg::COORD_BITS-1:0]  source_y,
	output logic                                         empty,
	input  wire logic                                    pop,
	output logic signed [psad_pkg::BEAR_BITS-1:0]        bearing_degrees,
	output logic [psad_pkg::QUO_BITS-1:0]                distance_byte,
	input  wire logic                                    cfg_wr_en,
	input  wire logic                                    cfg_index,
	input  wire logic [psad_pkg::DIST_BITS-1:0]          cfg_wdata
);

	localparam int L = psad_pkg::PIPE_LAT;

	logic [psad_pkg::DIST_BITS-1:0]        max_distance_q;
	logic                                  spatial_enable_q;
	logic                                  vld_s [1:L];
	logic                                  off_s [1:L];
	logic                                  adv;
	logic                                  avail;
	logic                                  take;
	psad_pkg::item_t                       head;
	logic signed [psad_pkg::BEAR_BITS-1:0] bearing;
	logic [psad_pkg::QUO_BITS-1:0]         distance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q   <= psad_pkg::MAX_DIST_RESET;
			spatial_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				psad_pkg::REG_MAX_DISTANCE:   max_distance_q   <= cfg_wdata;
				psad_pkg::REG_SPATIAL_ENABLE: spatial_enable_q <= cfg_wdata[0];
				default:                      max_distance_q   <= max_distance_q;
			endcase
		end
	end

	psad_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.listener_x     (listener_x),
		.listener_y     (listener_y),
		.source_x       (source_x),
		.source_y       (source_y),
		.spatial_enable (spatial_enable_q),
		.take           (take),
		.avail          (avail),
		.head           (head)
	);

	// Advance the back pipeline unless a finished result is waiting and not popped
	assign adv  = !vld_s[L] || pop;
	assign take = adv && avail;

	psad_cordic u_cordic (
		.clk     (clk),
		.en      (adv),
		.item    (head),
		.bearing (bearing)
	);

	psad_dist u_dist (
		.clk          (clk),
		.en           (adv),
		.item         (head),
		.max_distance (max_distance_q),
		.distance     (distance)
	);

	// Stage valid bits; the spatial-off mark rides along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= L; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= avail;
			for (int i = 2; i <= L; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s[1] <= head.off;
			for (int i = 2; i <= L; i++) begin
				off_s[i] <= off_s[i-1];
			end
		end
	end

	// Drop both outputs to zero when spatial mode was off at acceptance
	assign empty           = !vld_s[L];
	assign bearing_degrees = off_s[L] ? '0 : bearing;
	assign distance_byte   = off_s[L] ? '0 : distance;

endmodule
`default_nettype wire

// ----- rtl/core/psad_checker.sv -----
// Port-level checker of the bearing and distance block, bound to its top level.
`default_nettype none
module psad_checker (
	input wire logic                                    clk,
	input wire logic                                    arst_n,
	input wire logic                                    push,
	input wire logic                                    full,
	input wire logic                                    empty,
	input wire logic                                    pop,
	input wire logic signed [psad_pkg::BEAR_BITS-1:0]   bearing_degrees,
	input wire logic [psad_pkg::QUO_BITS-1:0]           distance_byte
);

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (bearing_degrees >= -psad_pkg::DEG180 && bearing_degrees <= psad_pkg::DEG180))
		else $error("bearing out of range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(bearing_degrees) && $stable(distance_byte)))
		else $error("stalled result changed");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue filled without a request");

endmodule

bind positional_sound_angle_distance psad_checker u_psad_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.push            (push),
	.full            (full),
	.empty           (empty),
	.pop             (pop),
	.bearing_degrees (bearing_degrees),
	.distance_byte   (distance_byte)
);
`default_nettype wire

// ----- sim/tb_positional_sound_angle_distance.sv -----
// Self-checking testbench for the positional sound bearing and distance block.
`timescale 1ns / 1ps
module tb_positional_sound_angle_distance;

	localparam int  DRAIN_CYCLES = 60;      // beyond the request-to-result latency
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [psad_pkg::BEAR_BITS-1:0] bearing;
		logic [psad_pkg::QUO_BITS-1:0]         atten;
	} sound_result_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [psad_pkg::COORD_BITS-1:0] listener_x, listener_y, source_x, source_y;
	logic empty;
	logic pop;
	logic signed [psad_pkg::BEAR_BITS-1:0] bearing_degrees;
	logic [psad_pkg::QUO_BITS-1:0] distance_byte;
	logic cfg_wr_en;
	logic cfg_index;
	logic [psad_pkg::DIST_BITS-1:0] cfg_wdata;

	// shadow copy of the block's registers, updated on each write
	logic [psad_pkg::DIST_BITS-1:0] cur_max_dist;
	logic cur_spatial;

	sound_result_t expected_results[$];
	int mismatches;
	int stray_results;
	longint cycles;

	// sender burst state: requests left in this burst
	int burst_left;

	positional_sound_angle_distance u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.listener_x(listener_x), .listener_y(listener_y),
		.source_x(source_x), .source_y(source_y),
		.empty(empty), .pop(pop),
		.bearing_degrees(bearing_degrees), .distance_byte(distance_byte),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// atan(2^-i) in degrees as Q.16
	function automatic longint atan_deg(input int i);
		longint tbl [0:23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return tbl[i];
	endfunction

	function automatic bit [63:0] int_sqrt(input bit [63:0] v);
		bit [63:0] root;
		bit [63:0] bitpos;
		root = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > v) bitpos >>= 2;
		while (bitpos != 0) begin
			if (v >= root + bitpos) begin
				v = v - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root >>= 1;
			end
			bitpos >>= 2;
		end
		return root;
	endfunction

	// vectoring CORDIC on (dy, -dx), angle kept in degrees Q.16
	function automatic logic signed [psad_pkg::BEAR_BITS-1:0] bearing_of(input longint dx,
		input longint dy);
		longint x, y, z, xs, ys, q;
		x = dy;
		y = -dx;
		z = 0;
		if (x == 0 && y == 0) return '0;
		if (x < 0 && y == 0) return -9'sd180;
		x = x <<< psad_pkg::PRESCALE;
		y = y <<< psad_pkg::PRESCALE;
		if (x < 0) begin
			z = (y > 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < psad_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_deg(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_deg(i);
			end
		end
		q = z / 65536;
		if (q > 180) q = 180;
		if (q < -180) q = -180;
		return q[psad_pkg::BEAR_BITS-1:0];
	endfunction

	function automatic logic [psad_pkg::QUO_BITS-1:0] attenuation_of(input longint dx,
		input longint dy);
		bit [63:0] m, ax, ay, s;
		m = 64'(cur_max_dist);
		if (m == 0) m = 1;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax >= m || ay >= m) return 8'd255;
		s = ax * ax + ay * ay;
		if (s >= m * m) return 8'd255;
		return psad_pkg::QUO_BITS'(int_sqrt(64'd65025 * s) / m);
	endfunction

	function automatic sound_result_t predict_sound(
		input logic signed [psad_pkg::COORD_BITS-1:0] lx,
		input logic signed [psad_pkg::COORD_BITS-1:0] ly,
		input logic signed [psad_pkg::COORD_BITS-1:0] sx,
		input logic signed [psad_pkg::COORD_BITS-1:0] sy);
		sound_result_t r;
		longint dx, dy;
		r = '0;
		if (!cur_spatial) return r;
		dx = longint'(lx) - longint'(sx);
		dy = longint'(ly) - longint'(sy);
		r.bearing = bearing_of(dx, dy);
		r.atten = attenuation_of(dx, dy);
		return r;
	endfunction

	// Drive one request and hold it until accepted; push stays high for the caller.
	task automatic send_request(input logic signed [psad_pkg::COORD_BITS-1:0] lx,
		input logic signed [psad_pkg::COORD_BITS-1:0] ly,
		input logic signed [psad_pkg::COORD_BITS-1:0] sx,
		input logic signed [psad_pkg::COORD_BITS-1:0] sy);
		int gap;
		// burst over: pick a new burst length and, for a nonzero random gap, drop push first
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		listener_x <= lx;
		listener_y <= ly;
		source_x <= sx;
		source_y <= sy;
		do @(posedge clk); while (full);
		expected_results.push_back(predict_sound(lx, ly, sx, sy));
	endtask

	// Drop push at once, let every outstanding result drain, then let the pipeline settle.
	task automatic wait_idle();
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [psad_pkg::DIST_BITS-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == psad_pkg::REG_MAX_DISTANCE) cur_max_dist = val;
		else cur_spatial = val[0];
	endtask

	function automatic logic signed [psad_pkg::COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 4))
			0: return psad_pkg::COORD_BITS'($urandom);
			1: return psad_pkg::COORD_BITS'($urandom_range(0, 200) - 100);
			2: return psad_pkg::COORD_BITS'($urandom_range(0, 60000) - 30000);
			3: return $urandom_range(0, 1)
				? psad_pkg::COORD_BITS'(24'sh7fffff - $urandom_range(0, 15))
				: psad_pkg::COORD_BITS'(-24'sh800000 + $urandom_range(0, 15));
			default: return psad_pkg::COORD_BITS'($urandom_range(0, 2000000) - 1000000);
		endcase
	endfunction

	// Reset state: spatial mode off, every result must be zero.
	task automatic test_spatial_off();
		send_request(24'sh7fffff, -24'sh800000, -24'sh800000, 24'sh7fffff);
		send_request(24'sd100, 24'sd0, 24'sd0, 24'sd0);
		send_request(24'sd0, 24'sd0, 24'sd0, 24'sd0);
		wait_idle();
	endtask

	// Corners: zero vector, straight behind, axes, extremes, distance right at the limit.
	task automatic test_directed();
		write_reg(psad_pkg::REG_SPATIAL_ENABLE, 24'd1);
		send_request(24'sd500, 24'sd500, 24'sd500, 24'sd500);
		send_request(24'sd0, -24'sd256, 24'sd0, 24'sd0);
		send_request(24'sd0, 24'sd256, 24'sd0, 24'sd0);
		send_request(24'sd256, 24'sd0, 24'sd0, 24'sd0);
		send_request(-24'sd256, 24'sd0, 24'sd0, 24'sd0);
		send_request(24'sd1, -24'sd1000, 24'sd0, 24'sd0);
		send_request(-24'sd1, -24'sd1000, 24'sd0, 24'sd0);
		send_request(24'sd300, 24'sd300, 24'sd0, 24'sd0);
		send_request(24'sd25600, 24'sd0, 24'sd0, 24'sd0);
		send_request(24'sd25599, 24'sd0, 24'sd0, 24'sd0);
		send_request(24'sd18101, 24'sd18101, 24'sd0, 24'sd0);
		send_request(24'sh7fffff, 24'sh7fffff, -24'sh800000, -24'sh800000);
		send_request(-24'sh800000, -24'sh800000, 24'sh7fffff, 24'sh7fffff);
		send_request(24'sh7fffff, -24'sh800000, -24'sh800000, 24'sh7fffff);
		send_request(24'sd0, -24'sh800000, 24'sd0, 24'sh7fffff);
		wait_idle();
		write_reg(psad_pkg::REG_MAX_DISTANCE, 24'd1);
		send_request(24'sd1, 24'sd0, 24'sd0, 24'sd0);
		send_request(24'sd0, 24'sd0, 24'sd0, 24'sd0);
		wait_idle();
		write_reg(psad_pkg::REG_MAX_DISTANCE, 24'hffffff);
		send_request(24'sh7fffff, 24'sh7fffff, -24'sh800000, -24'sh800000);
		send_request(24'sd1000, -24'sd77, 24'sd0, 24'sd0);
		wait_idle();
	endtask

	// Random requests across several register settings, one phase each.
	task automatic test_random_phases();
		logic [psad_pkg::DIST_BITS-1:0] dist_setting [0:5];
		dist_setting = '{24'd25600, 24'd1, 24'hffffff, 24'd3000, 24'd0, 24'd0};
		dist_setting[4] = psad_pkg::DIST_BITS'($urandom_range(1, 24'hffffff));
		dist_setting[5] = psad_pkg::DIST_BITS'($urandom_range(1, 70000));
		for (int p = 0; p < 6; p++) begin
			write_reg(psad_pkg::REG_MAX_DISTANCE, dist_setting[p]);
			write_reg(psad_pkg::REG_SPATIAL_ENABLE, (p == 3) ? 24'd0 : 24'd1);
			for (int k = 0; k < 85; k++)
				send_request(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			wait_idle();
		end
	endtask

	// Receiver: stalls on its own pattern, mixing full-rate, random and long-hold stretches.
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(5, 60);
			end
			left--;
			case (mode)
				0: pop <= 1'b1;
				1: pop <= $urandom_range(0, 1);
				default: pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		sound_result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				stray_results++;
				if (mismatches + stray_results <= 10)
					$display("unexpected result: bearing %0d dist %0d",
						bearing_degrees, distance_byte);
			end else begin
				want = expected_results.pop_front();
				if (want.bearing !== bearing_degrees || want.atten !== distance_byte) begin
					mismatches++;
					if (mismatches + stray_results <= 10)
						$display("mismatch: bearing exp %0d got %0d, dist exp %0d got %0d",
							want.bearing, bearing_degrees, want.atten, distance_byte);
				end
			end
		end
	end

	// Watchdog: end the run on a hang.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("positional_sound_angle_distance verification failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		stray_results = 0;
		cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		push = 1'b0;
		listener_x = '0;
		listener_y = '0;
		source_x = '0;
		source_y = '0;
		cfg_wr_en = 1'b0;
		cfg_index = psad_pkg::REG_MAX_DISTANCE;
		cfg_wdata = '0;
		cur_max_dist = psad_pkg::MAX_DIST_RESET;
		cur_spatial = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_spatial_off();
		test_directed();
		test_random_phases();

		if (mismatches == 0 && stray_results == 0 && expected_results.size() == 0)
			$display("positional_sound_angle_distance verification clean");
		else
			$display("positional_sound_angle_distance verification failed");
		$finish;
	end

endmodule
